[rtl/nkm_pkg.sv]
// ----------------------------------------------------------------------------
// nkm_pkg
// shared types and constants for the navigation key merger
// ----------------------------------------------------------------------------
package nkm_pkg;

   localparam int NUM_KEYS = 16;
   localparam int KEY_W    = 4;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [KEY_W-1:0] KEY_NONE  = 4'd0;
   localparam logic [KEY_W-1:0] KEY_UP    = 4'd1;
   localparam logic [KEY_W-1:0] KEY_DOWN  = 4'd2;
   localparam logic [KEY_W-1:0] KEY_LEFT  = 4'd3;
   localparam logic [KEY_W-1:0] KEY_RIGHT = 4'd4;

   localparam logic [1:0] OP_BUTTON_DOWN = 2'd0;
   localparam logic [1:0] OP_BUTTON_UP   = 2'd1;
   localparam logic [1:0] OP_AXIS        = 2'd2;
   localparam logic [1:0] OP_TICK        = 2'd3;

   localparam logic EV_PRESS   = 1'b0;
   localparam logic EV_RELEASE = 1'b1;

   localparam logic AXIS_HORIZONTAL = 1'b0;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DELAY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD   = 2'd2;

   localparam logic [CSR_W-1:0] FIRST_DELAY_RESET = 16'd500;
   localparam logic [CSR_W-1:0] PERIOD_RESET      = 16'd50;
   localparam logic [CSR_W-1:0] THRESHOLD_RESET   = 16'd9000;

   localparam logic [1:0] COUNT_MAX = 2'd3;

   typedef struct packed {
      logic [1:0]        operation;
      logic [KEY_W-1:0]  key;
      logic              axis;
      logic signed [15:0] axis_value;
      logic [31:0]       now_ms;
   } req_word_type;

   typedef struct packed {
      logic             event_kind;
      logic [KEY_W-1:0] event_key;
      logic             last;
   } rsp_word_type;

endpackage

[rtl/nav_key_merge_autorepeat.sv]
// ----------------------------------------------------------------------------
// nav_key_merge_autorepeat
// merges buttons and stick axes into key press/release words with auto-repeat
// ----------------------------------------------------------------------------
// while rsp_stall is low, the two-slot response buffer drains one word a cycle
//    and a request word is taken each cycle if each gives at most one response;
//    two responses from an axis change hold the next word until the last is taken
// an accepted word sits in the input register, then its responses in the buffer
// reset: synchronous, clears key state, repeat state and buffers, and loads
//    the default delay, period and threshold
module nav_key_merge_autorepeat (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  nkm_pkg::req_word_type           req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output nkm_pkg::rsp_word_type           rsp_word,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [nkm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nkm_pkg::CSR_W-1:0]       csr_data
);
   import nkm_pkg::*;

   logic [CSR_W-1:0] first_delay_ff, period_ff, threshold_ff;

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;

   logic [NUM_KEYS-1:0] held_ff, held_in;
   logic [1:0]          cnt_ff [NUM_KEYS];
   logic [1:0]          cnt_in [NUM_KEYS];
   logic [KEY_W-1:0]    axd_ff [2];
   logic [KEY_W-1:0]    axd_in [2];
   logic [KEY_W-1:0]    rk_ff, rk_in;
   logic [31:0]         rd_ff, rd_in;

   rsp_word_type slot0_ff, slot1_ff, slot0_in, slot1_in;
   logic [1:0]   out_cnt_ff, out_cnt_in;

   logic req_fire, rsp_fire, proc_go;

   logic [32:0] sum_first, sum_period;
   logic [31:0] due_first, due_period;
   logic [16:0] mag;
   logic [KEY_W-1:0] dir_key;

   rsp_word_type r0, r1;
   logic [1:0]   n;
   logic         do_on, do_off, found;
   logic [KEY_W-1:0] on_key, off_key;
   logic [1:0]   c;

   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = out_cnt_ff != 2'd0;
   assign rsp_word  = slot0_ff;
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign proc_go   = in_valid_ff &&
                      (out_cnt_ff == 2'd0 || (out_cnt_ff == 2'd1 && rsp_fire));
   assign req_stall = in_valid_ff && !proc_go;

   // saturating due times
   assign sum_first  = {1'b0, in_word_ff.now_ms} + {17'd0, first_delay_ff};
   assign sum_period = {1'b0, in_word_ff.now_ms} + {17'd0, period_ff};
   assign due_first  = sum_first[32] ? 32'hFFFF_FFFF : sum_first[31:0];
   assign due_period = sum_period[32] ? 32'hFFFF_FFFF : sum_period[31:0];

   // dead zone mapping
   always_comb begin
      mag = in_word_ff.axis_value[15] ? 17'(-{in_word_ff.axis_value[15], in_word_ff.axis_value})
                                      : {1'b0, in_word_ff.axis_value};
      if (mag < {1'b0, threshold_ff}) begin
         dir_key = KEY_NONE;
      end else if (in_word_ff.axis == AXIS_HORIZONTAL) begin
         dir_key = (!in_word_ff.axis_value[15] && in_word_ff.axis_value != 16'sd0)
                   ? KEY_RIGHT : KEY_LEFT;
      end else begin
         dir_key = (!in_word_ff.axis_value[15] && in_word_ff.axis_value != 16'sd0)
                   ? KEY_DOWN : KEY_UP;
      end
   end

   always_comb begin
      held_in = held_ff;
      cnt_in  = cnt_ff;
      axd_in  = axd_ff;
      rk_in   = rk_ff;
      rd_in   = rd_ff;
      r0      = '0;
      r1      = '0;
      n       = 2'd0;
      do_on   = 1'b0;
      do_off  = 1'b0;
      on_key  = KEY_NONE;
      off_key = KEY_NONE;
      found   = 1'b0;
      c       = 2'd0;

      case (in_word_ff.operation)
         OP_BUTTON_DOWN: begin
            if (in_word_ff.key != KEY_NONE && int'(in_word_ff.key) < NUM_KEYS &&
                !held_ff[in_word_ff.key]) begin
               held_in[in_word_ff.key] = 1'b1;
               do_on  = 1'b1;
               on_key = in_word_ff.key;
            end
         end
         OP_BUTTON_UP: begin
            if (in_word_ff.key != KEY_NONE && int'(in_word_ff.key) < NUM_KEYS &&
                held_ff[in_word_ff.key]) begin
               held_in[in_word_ff.key] = 1'b0;
               do_off  = 1'b1;
               off_key = in_word_ff.key;
            end
         end
         OP_AXIS: begin
            if (axd_ff[in_word_ff.axis] != dir_key) begin
               axd_in[in_word_ff.axis] = dir_key;
               do_off  = axd_ff[in_word_ff.axis] != KEY_NONE;
               off_key = axd_ff[in_word_ff.axis];
               do_on   = dir_key != KEY_NONE;
               on_key  = dir_key;
            end
         end
         default: begin
            if (rk_ff != KEY_NONE && in_word_ff.now_ms >= rd_ff) begin
               rd_in = due_period;
               r0    = '{event_kind: EV_PRESS, event_key: rk_ff, last: 1'b0};
               n     = 2'd1;
            end
         end
      endcase

      // release first, then press
      if (do_off && cnt_in[off_key] != 2'd0) begin
         cnt_in[off_key] = cnt_in[off_key] - 2'd1;
         if (cnt_in[off_key] == 2'd0) begin
            if (rk_in == off_key) begin
               rk_in = KEY_NONE;
               for (int d = int'(KEY_UP); d <= int'(KEY_RIGHT); d++) begin
                  if (!found && cnt_in[KEY_W'(d)] != 2'd0) begin
                     found = 1'b1;
                     rk_in = KEY_W'(d);
                     rd_in = due_first;
                  end
               end
            end
            r0 = '{event_kind: EV_RELEASE, event_key: off_key, last: 1'b0};
            n  = 2'd1;
         end
      end

      if (do_on) begin
         c = cnt_in[on_key];
         if (c < COUNT_MAX) begin
            cnt_in[on_key] = c + 2'd1;
         end
         if (c == 2'd0) begin
            if (on_key >= KEY_UP && on_key <= KEY_RIGHT) begin
               rk_in = on_key;
               rd_in = due_first;
            end
            if (n == 2'd0) begin
               r0 = '{event_kind: EV_PRESS, event_key: on_key, last: 1'b0};
            end else begin
               r1 = '{event_kind: EV_PRESS, event_key: on_key, last: 1'b0};
            end
            n = n + 2'd1;
         end
      end

      r0.last = n == 2'd1;
      r1.last = 1'b1;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (proc_go) begin
         in_valid_in = 1'b0;
      end
      slot0_in   = slot0_ff;
      slot1_in   = slot1_ff;
      out_cnt_in = out_cnt_ff;
      if (proc_go) begin
         slot0_in   = r0;
         slot1_in   = r1;
         out_cnt_in = n;
      end else if (rsp_fire) begin
         slot0_in   = slot1_ff;
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_word_ff <= req_word;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_cnt_ff     <= 2'd0;
         held_ff        <= '0;
         for (int i = 0; i < NUM_KEYS; i++) begin
            cnt_ff[i] <= 2'd0;
         end
         axd_ff[0]      <= KEY_NONE;
         axd_ff[1]      <= KEY_NONE;
         rk_ff          <= KEY_NONE;
         rd_ff          <= 32'd0;
         first_delay_ff <= FIRST_DELAY_RESET;
         period_ff      <= PERIOD_RESET;
         threshold_ff   <= THRESHOLD_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         out_cnt_ff  <= out_cnt_in;
         if (proc_go) begin
            held_ff <= held_in;
            cnt_ff  <= cnt_in;
            axd_ff  <= axd_in;
            rk_ff   <= rk_in;
            rd_ff   <= rd_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FIRST_DELAY: first_delay_ff <= csr_data;
               CSR_PERIOD:      period_ff      <= csr_data;
               CSR_THRESHOLD:   threshold_ff   <= csr_data;
               default: ;
            endcase
         end
      end
   end

   a_out_cnt_range: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3)
      else $error("response buffer count out of range");

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff == 2'd1 |-> slot0_ff.last)
      else $error("lone buffered word not marked last");

   a_pair_head_not_last: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff == 2'd2 |-> !slot0_ff.last && slot1_ff.last)
      else $error("word pair marked wrongly");

   a_repeat_key_active: assert property (@(posedge clock) disable iff (reset)
      rk_ff != KEY_NONE |-> cnt_ff[rk_ff] != 2'd0)
      else $error("repeat key has no active source");

endmodule

[tb/tb_nav_key_merge_autorepeat.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nav_key_merge_autorepeat
// drives button, axis and tick words into the key merger and checks every
// press/release word against the directed table or an in-bench key state model;
// the table runs first, then random traffic over several register settings with
// bursty input, random output stalls and one long output hold-off
// ----------------------------------------------------------------------------
module tb_nav_key_merge_autorepeat;
   import nkm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int BY_MODEL = -1;
   localparam int RANDOM_PER_PHASE = 77;
   localparam int REQ_W = $bits(req_word_type);

   typedef struct {
      req_word_type w;
      int           n;
      rsp_word_type r0;
      rsp_word_type r1;
   } key_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data = '0;

   // key state model
   logic [CSR_W-1:0] cfg_delay  = FIRST_DELAY_RESET;
   logic [CSR_W-1:0] cfg_period = PERIOD_RESET;
   logic [CSR_W-1:0] cfg_thresh = THRESHOLD_RESET;
   logic             held_btn [NUM_KEYS] = '{default: 1'b0};
   logic [1:0]       src_cnt  [NUM_KEYS] = '{default: 2'd0};
   logic [KEY_W-1:0] axis_dir [2] = '{default: KEY_NONE};
   logic [KEY_W-1:0] rep_key = KEY_NONE;
   logic [31:0]      rep_due = '0;

   rsp_word_type step_events [$];
   rsp_word_type key_events_q [$];
   key_row_type  row_tags_q [$];
   key_row_type  dir_rows [$];

   int          fail_cnt = 0;
   logic [31:0] now_cnt = '0;
   bit          hold_rsp = 1'b0;

   nav_key_merge_autorepeat i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [31:0] due_after(logic [31:0] now, logic [CSR_W-1:0] d);
      logic [32:0] s;
      s = {1'b0, now} + {17'd0, d};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [KEY_W-1:0] axis_to_key(logic ax, logic signed [15:0] v);
      int sv;
      int mag;
      sv  = v;
      mag = (sv < 0) ? -sv : sv;
      if (mag < int'(cfg_thresh)) return KEY_NONE;
      if (ax == AXIS_HORIZONTAL) return (sv > 0) ? KEY_RIGHT : KEY_LEFT;
      return (sv > 0) ? KEY_DOWN : KEY_UP;
   endfunction

   task automatic add_event(logic kind, logic [KEY_W-1:0] k);
      rsp_word_type r;
      r.event_kind = kind;
      r.event_key  = k;
      r.last       = 1'b0;
      if (step_events.size() < 2) step_events.push_back(r);
   endtask

   task automatic source_on(logic [KEY_W-1:0] k, logic [31:0] now);
      logic [1:0] c;
      c = src_cnt[k];
      if (c < COUNT_MAX) src_cnt[k] = c + 2'd1;
      if (c == 2'd0) begin
         if (k >= KEY_UP && k <= KEY_RIGHT) begin
            rep_key = k;
            rep_due = due_after(now, cfg_delay);
         end
         add_event(EV_PRESS, k);
      end
   endtask

   task automatic source_off(logic [KEY_W-1:0] k, logic [31:0] now);
      if (src_cnt[k] != 2'd0) begin
         src_cnt[k] = src_cnt[k] - 2'd1;
         if (src_cnt[k] == 2'd0) begin
            if (rep_key == k) begin
               rep_key = KEY_NONE;
               // repeat moves to the first direction still held
               for (int d = KEY_UP; d <= KEY_RIGHT; d++) begin
                  if (src_cnt[KEY_W'(d)] != 2'd0 && rep_key == KEY_NONE) begin
                     rep_key = KEY_W'(d);
                     rep_due = due_after(now, cfg_delay);
                  end
               end
            end
            add_event(EV_RELEASE, k);
         end
      end
   endtask

   task automatic compute_keys(req_word_type w);
      logic [KEY_W-1:0] prv;
      logic [KEY_W-1:0] nxt;
      step_events.delete();
      case (w.operation)
         OP_BUTTON_DOWN, OP_BUTTON_UP: begin
            if (w.key != KEY_NONE && int'(w.key) < NUM_KEYS) begin
               if (w.operation == OP_BUTTON_DOWN && !held_btn[w.key]) begin
                  held_btn[w.key] = 1'b1;
                  source_on(w.key, w.now_ms);
               end else if (w.operation == OP_BUTTON_UP && held_btn[w.key]) begin
                  held_btn[w.key] = 1'b0;
                  source_off(w.key, w.now_ms);
               end
            end
         end
         OP_AXIS: begin
            prv = axis_dir[w.axis];
            nxt = axis_to_key(w.axis, w.axis_value);
            if (prv != nxt) begin
               if (prv != KEY_NONE) source_off(prv, w.now_ms);
               axis_dir[w.axis] = nxt;
               if (nxt != KEY_NONE) source_on(nxt, w.now_ms);
            end
         end
         default: begin
            if (rep_key != KEY_NONE && w.now_ms >= rep_due) begin
               rep_due = due_after(w.now_ms, cfg_period);
               add_event(EV_PRESS, rep_key);
            end
         end
      endcase
      if (step_events.size() > 0) step_events[step_events.size()-1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      key_row_type  tag;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (key_events_q.size() == 0) begin
               $error("unexpected response word: event_kind %0d event_key %0d last %0d",
                      rsp_word.event_kind, rsp_word.event_key, rsp_word.last);
               fail_cnt++;
            end else begin
               want = key_events_q.pop_front();
               if (rsp_word.event_kind !== want.event_kind) begin
                  $error("event_kind: expected %0d, got %0d", want.event_kind,
                         rsp_word.event_kind);
                  fail_cnt++;
               end
               if (rsp_word.event_key !== want.event_key) begin
                  $error("event_key: expected %0d, got %0d", want.event_key,
                         rsp_word.event_key);
                  fail_cnt++;
               end
               if (rsp_word.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_word.last);
                  fail_cnt++;
               end
            end
         end
         if (req_valid && !req_stall && row_tags_q.size() > 0) begin
            tag = row_tags_q.pop_front();
            compute_keys(req_word);
            if (tag.n == BY_MODEL) begin
               foreach (step_events[i]) key_events_q.push_back(step_events[i]);
            end else begin
               if (tag.n >= 1) key_events_q.push_back(tag.r0);
               if (tag.n >= 2) key_events_q.push_back(tag.r1);
            end
         end
      end
   end

   // receiver: switches between random stall patterns, plus one long hold-off
   initial begin
      int  mode;
      int  left;
      int  hold_left;
      logic stall_v;
      mode = 0;
      left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_rsp) hold_left = 150;
         if (hold_left > 0) begin
            stall_v = 1'b1;
            hold_left--;
            if (hold_left == 0) hold_rsp = 1'b0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(20, 80);
            end
            left--;
            case (mode)
               0: stall_v = 1'b0;
               1: stall_v = ($urandom_range(0, 9) < 3);
               2: stall_v = ($urandom_range(0, 9) < 8);
               default: stall_v = ((left % 4) != 0);
            endcase
         end
         rsp_stall <= stall_v;
      end
   end

   task automatic add_row(logic [1:0] op, logic [KEY_W-1:0] k, logic ax, int v,
                          logic [31:0] now, int n, logic kind0, logic [KEY_W-1:0] key0,
                          logic kind1, logic [KEY_W-1:0] key1);
      key_row_type row;
      row.w.operation  = op;
      row.w.key        = k;
      row.w.axis       = ax;
      row.w.axis_value = 16'(v);
      row.w.now_ms     = now;
      row.n            = n;
      row.r0.event_kind = kind0;
      row.r0.event_key  = key0;
      row.r0.last       = (n == 1);
      row.r1.event_kind = kind1;
      row.r1.event_key  = key1;
      row.r1.last       = 1'b1;
      dir_rows.push_back(row);
   endtask

   task automatic send_word(req_word_type w, key_row_type tag);
      @(negedge clock);
      row_tags_q.push_back(tag);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_req(int n);
      @(negedge clock);
      req_valid <= 1'b0;
      req_word  <= req_word_type'(REQ_W'({$urandom, $urandom}));
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic drain();
      int waited;
      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (key_events_q.size() != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      if (key_events_q.size() != 0) begin
         $error("%0d expected response words never arrived", key_events_q.size());
         fail_cnt++;
         key_events_q.delete();
      end
      // words that give no response may still be in flight
      repeat (12) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] d);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FIRST_DELAY: cfg_delay  = d;
         CSR_PERIOD:      cfg_period = d;
         CSR_THRESHOLD:   cfg_thresh = d;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(logic [CSR_W-1:0] d, logic [CSR_W-1:0] p, logic [CSR_W-1:0] t);
      write_csr(CSR_FIRST_DELAY, d);
      write_csr(CSR_PERIOD, p);
      write_csr(CSR_THRESHOLD, t);
   endtask

   task automatic next_item(output req_word_type w);
      int          thr;
      int          v;
      int unsigned inc;
      logic [32:0] sum;
      w = req_word_type'(REQ_W'({$urandom, $urandom}));
      case ($urandom_range(0, 9))
         0, 1, 2: inc = $urandom_range(0, 2);
         3, 4, 5, 6, 7: inc = $urandom_range(0, int'(cfg_period) * 2 + 2);
         8: inc = $urandom_range(0, int'(cfg_delay) + int'(cfg_period) + 2);
         default: inc = $urandom_range(0, 1000);
      endcase
      sum = {1'b0, now_cnt} + 33'(inc);
      now_cnt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      w.now_ms = now_cnt;
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6: w.operation = OP_TICK;
         7, 8, 9, 10, 11: begin
            w.operation = OP_BUTTON_DOWN;
            case ($urandom_range(0, 9))
               0: w.key = KEY_NONE;
               1: w.key = KEY_W'($urandom_range(5, 15));
               default: w.key = KEY_W'($urandom_range(KEY_UP, KEY_RIGHT));
            endcase
         end
         12, 13, 14, 15: begin
            w.operation = OP_BUTTON_UP;
            w.key = ($urandom_range(0, 9) < 7) ? KEY_W'($urandom_range(KEY_UP, KEY_RIGHT))
                                                : KEY_W'($urandom_range(0, 15));
         end
         default: begin
            w.operation = OP_AXIS;
            thr = cfg_thresh;
            case ($urandom_range(0, 7))
               0: v = 0;
               1: v = thr;
               2: v = -thr;
               3: v = thr - 1;
               4: v = -(thr - 1);
               5: v = -32768;
               6: v = 32767;
               default: v = $urandom_range(0, 65535) - 32768;
            endcase
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            w.axis_value = 16'(v);
         end
      endcase
   endtask

   task automatic run_random(int target);
      int           sent;
      int           burst;
      int           gap;
      req_word_type w;
      key_row_type  tag;
      tag.n = BY_MODEL;
      sent = 0;
      while (sent < target) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            if (sent < target) begin
               next_item(w);
               send_word(w, tag);
               sent++;
            end
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) idle_req(gap);
      end
   endtask

   task automatic fill_under_hold(int n);
      req_word_type w;
      key_row_type  tag;
      tag.n = BY_MODEL;
      hold_rsp = 1'b1;
      repeat (n) begin
         next_item(w);
         send_word(w, tag);
      end
   endtask

   initial begin
      // directed rows: op, key, axis, value, time, results, then up to two words
      add_row(OP_TICK, KEY_NONE, 1'b0, 0, 32'd0, 0, EV_PRESS, KEY_NONE, EV_PRESS, KEY_NONE);
      add_row(OP_BUTTON_DOWN, KEY_NONE, 1'b1, -1, 32'd1, 0,
              EV_PRESS, KEY_NONE, EV_PRESS, KEY_NONE);
      add_row(OP_BUTTON_UP, 4'd5, 1'b0, 0, 32'd1, 0, EV_PRESS, KEY_NONE, EV_PRESS, KEY_NONE);
      add_row(OP_BUTTON_DOWN, 4'd15, 1'b0, 0, 32'd2, 1, EV_PRESS, 4'd15, EV_PRESS, KEY_NONE);
      add_row(OP_BUTTON_DOWN, 4'd15, 1'b0, 0, 32'd2, 0, EV_PRESS, KEY_NONE, EV_PRESS, KEY_NONE);
      add_row(OP_BUTTON_UP, 4'd15, 1'b0, 0, 32'd3, 1, EV_RELEASE, 4'd15, EV_PRESS, KEY_NONE);
      add_row(OP_BUTTON_DOWN, KEY_UP, 1'b0, 0, 32'd10, 1, EV_PRESS, KEY_UP, EV_PRESS, KEY_NONE);
      add_row(OP_TICK, 4'd9, 1'b1, 12345, 32'd509, 0, EV_PRESS, KEY_NONE, EV_PRESS, KEY_NONE);
      add_row(OP_TICK, KEY_NONE, 1'b0, 0, 32'd510, 1, EV_PRESS, KEY_UP, EV_PRESS, KEY_NONE);
      add_row(OP_AXIS, 4'd15, 1'b1, -32768, 32'd520, 0,
              EV_PRESS, KEY_NONE, EV_PRESS, KEY_NONE);
      add_row(OP_BUTTON_UP, KEY_UP, 1'b0, 0, 32'd530, 0, EV_PRESS, KEY_NONE, EV_PRESS, KEY_NONE);
      add_row(OP_AXIS, KEY_NONE, 1'b1, 32767, 32'd540, 2, EV_RELEASE, KEY_UP, EV_PRESS, KEY_DOWN);
      add_row(OP_AXIS, KEY_NONE, 1'b0, 8999, 32'd550, 0, EV_PRESS, KEY_NONE, EV_PRESS, KEY_NONE);
      add_row(OP_AXIS, KEY_NONE, 1'b0, 9000, 32'd560, 1, EV_PRESS, KEY_RIGHT, EV_PRESS, KEY_NONE);
      add_row(OP_AXIS, KEY_NONE, 1'b0, -9000, 32'd570, 2,
              EV_RELEASE, KEY_RIGHT, EV_PRESS, KEY_LEFT);
      add_row(OP_AXIS, KEY_NONE, 1'b0, 0, 32'd580, 1, EV_RELEASE, KEY_LEFT, EV_PRESS, KEY_NONE);
      add_row(OP_TICK, KEY_NONE, 1'b0, 0, 32'd1080, 1, EV_PRESS, KEY_DOWN, EV_PRESS, KEY_NONE);
      add_row(OP_AXIS, KEY_NONE, 1'b1, 0, 32'd1100, 1, EV_RELEASE, KEY_DOWN, EV_PRESS, KEY_NONE);
      add_row(OP_TICK, KEY_NONE, 1'b0, 0, 32'd2000, 0, EV_PRESS, KEY_NONE, EV_PRESS, KEY_NONE);
      add_row(OP_BUTTON_DOWN, 4'd7, 1'b1, -1, 32'd2001, 1, EV_PRESS, 4'd7, EV_PRESS, KEY_NONE);
      add_row(OP_BUTTON_UP, 4'd7, 1'b0, 0, 32'd2002, 1, EV_RELEASE, 4'd7, EV_PRESS, KEY_NONE);
      add_row(OP_BUTTON_DOWN, KEY_LEFT, 1'b0, 0, 32'd2010, 1,
              EV_PRESS, KEY_LEFT, EV_PRESS, KEY_NONE);
      add_row(OP_BUTTON_DOWN, KEY_RIGHT, 1'b0, 0, 32'd2020, 1,
              EV_PRESS, KEY_RIGHT, EV_PRESS, KEY_NONE);
      add_row(OP_BUTTON_UP, KEY_RIGHT, 1'b0, 0, 32'd2030, 1,
              EV_RELEASE, KEY_RIGHT, EV_PRESS, KEY_NONE);
      add_row(OP_TICK, KEY_NONE, 1'b0, 0, 32'd2530, BY_MODEL,
              EV_PRESS, KEY_NONE, EV_PRESS, KEY_NONE);
      add_row(OP_BUTTON_UP, KEY_LEFT, 1'b0, 0, 32'd2540, BY_MODEL,
              EV_PRESS, KEY_NONE, EV_PRESS, KEY_NONE);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].w, dir_rows[i]);
         if ($urandom_range(0, 2) == 0) idle_req($urandom_range(1, 4));
      end
      now_cnt = 32'd3000;
      run_random(RANDOM_PER_PHASE);
      drain();

      // zero delay, zero period, zero threshold
      set_config(16'd0, 16'd0, 16'd0);
      run_random(RANDOM_PER_PHASE);
      drain();

      set_config(16'hFFFF, 16'hFFFF, 16'd32768);
      run_random(RANDOM_PER_PHASE);
      drain();

      set_config(16'd20, 16'd1, 16'd1);
      write_csr(CSR_UNUSED, 16'hFFFF);
      fill_under_hold(40);
      run_random(RANDOM_PER_PHASE);
      drain();

      // defaults again, with time close to the top so due times saturate
      set_config(FIRST_DELAY_RESET, PERIOD_RESET, THRESHOLD_RESET);
      now_cnt = 32'hFFFF_FE00;
      run_random(RANDOM_PER_PHASE);
      drain();

      repeat (20) @(posedge clock);
      if (fail_cnt == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[files.f]
rtl/nkm_pkg.sv
rtl/nav_key_merge_autorepeat.sv
tb/tb_nav_key_merge_autorepeat.sv
